### hw/rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// shared types and codes of the priority interrupt controller
// ----------------------------------------------------------------------------
package pic_pkg;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_LINE    = 2'd2;

	localparam logic       PORT_CMD     = 1'b0;
	localparam logic       PORT_DATA    = 1'b1;

	localparam logic [1:0] OCW3_READ_IRR = 2'd2;
	localparam logic [1:0] OCW3_READ_ISR = 2'd3;

	localparam logic [2:0] OCW2_ROT_CLEAR   = 3'd0;
	localparam logic [2:0] OCW2_NS_EOI      = 3'd1;
	localparam logic [2:0] OCW2_NOP         = 3'd2;
	localparam logic [2:0] OCW2_SP_EOI      = 3'd3;
	localparam logic [2:0] OCW2_ROT_INC     = 3'd4;
	localparam logic [2:0] OCW2_NS_EOI_ROT  = 3'd5;
	localparam logic [2:0] OCW2_SET_BASE    = 3'd6;
	localparam logic [2:0] OCW2_SP_EOI_ROT  = 3'd7;

	localparam logic [7:0] READ_IDLE    = 8'hff;
	localparam logic [7:0] MASK_RESET   = 8'hff;

	typedef struct packed {
		logic [1:0] mode;
		logic       address;
		logic [7:0] write_data;
		logic [2:0] irq_line;
	} pic_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       int_raise;
		logic [7:0] int_vector;
		logic [7:0] pending_bits;
	} pic_res_t;

endpackage

### hw/rtl/pic_stream_if.sv
// ----------------------------------------------------------------------------
// pic_stream_if
// valid/ready channel carrying one payload word per request
// ----------------------------------------------------------------------------
interface pic_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/priority_interrupt_controller.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller
// eight-line programmable interrupt controller in the 8259A style
// ----------------------------------------------------------------------------
// the request channel carries bus writes, bus reads and interrupt line
// requests; every accepted request yields exactly one item on the result
// channel with the read byte, the issued interrupt and the pending lines.
// a request is registered on acceptance and worked by one pass of logic
// (command decode, end-of-interrupt search and the ordered sweep of pending
// lines) into the result register, which drives the result channel.
// throughput is one request per cycle while the result channel is not
// stalled; the controller state is updated in that same pass, so each
// request sees the effect of the one before.
// a stalled result channel holds the result register; the input register
// still takes one more request, after which ready drops until the result
// is taken.
// reset leaves all lines masked, nothing in service or pending, no
// initialisation words expected and both channels empty.
// ----------------------------------------------------------------------------
module priority_interrupt_controller (
	input  logic         clk,
	input  logic         arst_n,
	pic_stream_if.sink   request,
	pic_stream_if.source result
);

	typedef struct packed {
		logic [7:0] svc;
		logic [7:0] req;
		logic       issue;
		logic [2:0] line;
	} offer_t;

	logic [7:0]         mask_q;
	logic [7:0]         service_q;
	logic [7:0]         pending_q;
	logic [2:0]         rot_base_q;
	logic               exp_icw2_q;
	logic               exp_icw3_q;
	logic               exp_icw4_q;
	logic               rb_armed_q;
	logic [7:0]         rb_latch_q;
	logic [4:0]         vec_base_q;

	logic               item_valid_s1;
	pic_pkg::pic_req_t  item_s1;
	logic               res_valid_s2;
	pic_pkg::pic_res_t  res_s2;

	logic               advance;

	logic [7:0]         mask_n;
	logic [7:0]         service_n;
	logic [7:0]         pending_n;
	logic [2:0]         rot_base_n;
	logic               exp_icw2_n;
	logic               exp_icw3_n;
	logic               exp_icw4_n;
	logic               rb_armed_n;
	logic [7:0]         rb_latch_n;
	logic [4:0]         vec_base_n;
	logic [7:0]         read_n;
	logic [7:0]         elig;
	logic [15:0]        svc_twice;
	logic [7:0]         svc_rot;
	logic               eoi_found;
	logic [2:0]         eoi_ofs;
	logic [2:0]         eoi_line;
	logic [2:0]         ocw_n;
	logic               not_init;
	offer_t             offer;
	pic_pkg::pic_res_t  res_n;

	// ordered offer of eligible lines, lowest first
	function automatic offer_t offer_lines(logic [7:0] el, logic [7:0] svc, logic [7:0] rq);
		offer_t r;
		logic   lower;
		r.svc = svc;
		r.req = rq;
		r.issue = 1'b0;
		r.line = 3'd0;
		lower = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (el[k]) begin
				if (r.svc[k]) begin
					r.svc[k] = 1'b0;
					r.req[k] = 1'b1;
				end else if (!lower) begin
					r.req[k] = 1'b0;
					r.svc[k] = 1'b1;
					r.issue = 1'b1;
					r.line = 3'(k);
				end else begin
					r.req[k] = 1'b1;
				end
			end
			lower = lower | r.svc[k];
		end
		return r;
	endfunction

	assign advance       = item_valid_s1 && (!res_valid_s2 || result.ready);
	assign request.ready = !item_valid_s1 || advance;
	assign result.valid  = res_valid_s2;
	assign result.payload = res_s2;

	// rotated in-service search for non-specific eoi
	assign svc_twice = {service_q, service_q} >> rot_base_q;
	assign svc_rot   = svc_twice[7:0];
	assign ocw_n     = item_s1.write_data[2:0];

	always_comb begin
		eoi_found = 1'b0;
		eoi_ofs   = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (svc_rot[k]) begin
				eoi_found = 1'b1;
				eoi_ofs   = 3'(k);
			end
		end
	end

	assign eoi_line = eoi_ofs + rot_base_q;

	always_comb begin
		mask_n     = mask_q;
		service_n  = service_q;
		pending_n  = pending_q;
		rot_base_n = rot_base_q;
		exp_icw2_n = exp_icw2_q;
		exp_icw3_n = exp_icw3_q;
		exp_icw4_n = exp_icw4_q;
		rb_armed_n = rb_armed_q;
		rb_latch_n = rb_latch_q;
		vec_base_n = vec_base_q;
		read_n     = pic_pkg::READ_IDLE;
		elig       = 8'd0;
		not_init   = 1'b0;

		case (item_s1.mode)
			pic_pkg::MODE_WRITE: begin
				if (item_s1.address == pic_pkg::PORT_CMD) begin
					if (item_s1.write_data[4]) begin
						exp_icw2_n = 1'b1;
						exp_icw3_n = !item_s1.write_data[1];
						exp_icw4_n = item_s1.write_data[0];
					end else if (item_s1.write_data[3]) begin
						if (item_s1.write_data[1:0] == pic_pkg::OCW3_READ_IRR) begin
							rb_armed_n = 1'b1;
							rb_latch_n = pending_q;
						end else if (item_s1.write_data[1:0] == pic_pkg::OCW3_READ_ISR) begin
							rb_armed_n = 1'b1;
							rb_latch_n = service_q & ~mask_q;
						end
					end else begin
						case (item_s1.write_data[7:5])
							pic_pkg::OCW2_ROT_CLEAR: rot_base_n = 3'd0;
							pic_pkg::OCW2_NS_EOI, pic_pkg::OCW2_NS_EOI_ROT: begin
								if (eoi_found) begin
									service_n[eoi_line] = 1'b0;
									pending_n[eoi_line] = 1'b0;
									if (item_s1.write_data[7:5] == pic_pkg::OCW2_NS_EOI_ROT)
										rot_base_n = rot_base_q + 3'd1;
								end
							end
							pic_pkg::OCW2_NOP: ;
							pic_pkg::OCW2_SP_EOI, pic_pkg::OCW2_SP_EOI_ROT: begin
								if (service_q[ocw_n]) begin
									service_n[ocw_n] = 1'b0;
									pending_n[ocw_n] = 1'b0;
									if (item_s1.write_data[7:5] == pic_pkg::OCW2_SP_EOI_ROT)
										rot_base_n = rot_base_q + 3'd1;
								end
							end
							pic_pkg::OCW2_ROT_INC:  rot_base_n = rot_base_q + 3'd1;
							pic_pkg::OCW2_SET_BASE: rot_base_n = ocw_n;
							default: ;
						endcase
					end
				end else begin
					if (exp_icw2_q) begin
						vec_base_n = item_s1.write_data[7:3];
						exp_icw2_n = 1'b0;
					end else if (exp_icw3_q) begin
						exp_icw3_n = 1'b0;
					end else if (exp_icw4_q) begin
						exp_icw4_n = 1'b0;
					end else begin
						mask_n    = item_s1.write_data;
						service_n = service_q & item_s1.write_data;
						pending_n = pending_q & item_s1.write_data;
					end
				end
				not_init = exp_icw2_n | exp_icw3_n | exp_icw4_n;
				elig = pending_n & ~mask_n & {8{!not_init}};
			end
			pic_pkg::MODE_READ: begin
				if (item_s1.address == pic_pkg::PORT_DATA) begin
					read_n = mask_q;
				end else if (rb_armed_q) begin
					rb_armed_n = 1'b0;
					read_n     = rb_latch_q;
				end
			end
			pic_pkg::MODE_LINE: begin
				not_init = exp_icw2_q | exp_icw3_q | exp_icw4_q;
				elig = (8'd1 << item_s1.irq_line) & ~mask_q & {8{!not_init}};
			end
			default: ;
		endcase

		offer = offer_lines(elig, service_n, pending_n);

		res_n.read_data    = read_n;
		res_n.int_raise    = offer.issue;
		res_n.int_vector   = offer.issue ? {vec_base_n, offer.line} : 8'd0;
		res_n.pending_bits = offer.req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q        <= pic_pkg::MASK_RESET;
			service_q     <= 8'd0;
			pending_q     <= 8'd0;
			rot_base_q    <= 3'd0;
			exp_icw2_q    <= 1'b0;
			exp_icw3_q    <= 1'b0;
			exp_icw4_q    <= 1'b0;
			rb_armed_q    <= 1'b0;
			rb_latch_q    <= 8'd0;
			vec_base_q    <= 5'd0;
			item_valid_s1 <= 1'b0;
			res_valid_s2  <= 1'b0;
		end else begin
			if (request.valid && request.ready) begin
				item_valid_s1 <= 1'b1;
			end else if (advance) begin
				item_valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_s2 <= 1'b1;
				mask_q       <= mask_n;
				service_q    <= offer.svc;
				pending_q    <= offer.req;
				rot_base_q   <= rot_base_n;
				exp_icw2_q   <= exp_icw2_n;
				exp_icw3_q   <= exp_icw3_n;
				exp_icw4_q   <= exp_icw4_n;
				rb_armed_q   <= rb_armed_n;
				rb_latch_q   <= rb_latch_n;
				vec_base_q   <= vec_base_n;
			end else if (result.ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready)
			item_s1 <= request.payload;
		if (advance)
			res_s2 <= res_n;
	end

	// issued line is in service and no longer pending
	a_issue_in_service: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && offer.issue) |=>
			(service_q[$past(offer.line)] && !pending_q[$past(offer.line)]))
		else $error("issued line not moved into service");

	// nothing is issued before initialisation completes
	a_issue_init: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && offer.issue) |=> (!exp_icw2_q && !exp_icw3_q && !exp_icw4_q))
		else $error("interrupt issued while initialisation words expected");

	// a vector is only shown with an interrupt
	a_vector_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && !res_s2.int_raise) |-> (res_s2.int_vector == 8'd0))
		else $error("vector without interrupt");

	// stalled input stage holds its request
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && !advance) |=> (item_valid_s1 && $stable(item_s1)))
		else $error("input stage lost a stalled request");

	// result pending bits follow the state written in the same pass
	a_pending_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_s2.pending_bits == pending_q))
		else $error("pending bits out of step with request register");

endmodule

### bench/priority_interrupt_controller_tb.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller_tb
// self-checking bench for the eight-line priority interrupt controller
// ----------------------------------------------------------------------------
// a queue of bus writes, bus reads and line requests feeds a clocked driver.
// each accepted request is run through a behavioural copy of the controller
// to predict its result. a clocked monitor compares every result field by
// field. a short directed opening walks through initialisation, masking,
// nesting, readback and every end-of-interrupt and rotation command. random
// sequences follow, mostly well-formed, with some noise. both channels idle
// in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int TOTAL_REQUESTS = 650;
	localparam int CALM_TAIL      = 60;
	localparam int QUIET_LIMIT    = 1000;
	localparam int SETTLE_CYCLES  = 8;

	logic clk;
	logic arst_n;

	pic_stream_if #(.payload_t(pic_pkg::pic_req_t)) req_ch ();
	pic_stream_if #(.payload_t(pic_pkg::pic_res_t)) res_ch ();

	priority_interrupt_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (res_ch)
	);

	pic_pkg::pic_req_t request_backlog[$];
	pic_pkg::pic_res_t predicted_results[$];

	int total_requests;
	int drain_point;
	int sent;
	int mismatches;
	int send_gap;
	int take_gap;
	int quiet_cycles;
	logic [31:0] cycle_no;
	logic calm;

	pic_pkg::pic_res_t next_res;
	pic_pkg::pic_res_t got_res;
	pic_pkg::pic_res_t want_res;

	// predicted controller state
	logic [7:0] prd_mask;
	logic [7:0] prd_in_service;
	logic [7:0] prd_irr;
	logic [2:0] prd_rot_base;
	logic       prd_need_icw2;
	logic       prd_need_icw3;
	logic       prd_need_icw4;
	logic       prd_rb_armed;
	logic [7:0] prd_rb_byte;
	logic [4:0] prd_vec_base;
	logic       prd_raised;
	logic [7:0] prd_vector;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		res_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_no, msg);
	endtask

	function automatic logic idling_allowed();
		return !calm && (cycle_no[7:6] != 2'b00);
	endfunction

	task automatic offer_line(input logic [2:0] line);
		logic [7:0] b;
		b = 8'd1 << line;
		if (prd_need_icw2 || prd_need_icw3 || prd_need_icw4)
			return;
		if ((prd_mask & b) != 0)
			return;
		if ((prd_in_service & b) != 0) begin
			prd_in_service &= ~b;
			prd_irr |= b;
			return;
		end
		// fixed priority: anything lower in service blocks the line
		if ((prd_in_service & (b - 8'd1)) != 0) begin
			prd_irr |= b;
			return;
		end
		prd_irr &= ~b;
		prd_in_service |= b;
		prd_raised = 1'b1;
		prd_vector = {prd_vec_base, line};
	endtask

	task automatic clear_first_in_service(output logic found);
		logic [2:0] pos;
		found = 1'b0;
		for (int k = 0; k < 8; k++) begin
			pos = prd_rot_base + k[2:0];
			if (!found && prd_in_service[pos]) begin
				prd_in_service[pos] = 1'b0;
				prd_irr[pos] = 1'b0;
				found = 1'b1;
			end
		end
	endtask

	task automatic bus_write(input logic port, input logic [7:0] d);
		logic [7:0] b;
		logic found;
		b = 8'd1 << d[2:0];
		if (port == pic_pkg::PORT_CMD) begin
			if (d[4]) begin
				prd_need_icw2 = 1'b1;
				prd_need_icw3 = !d[1];
				prd_need_icw4 = d[0];
			end else if (d[3]) begin
				if (d[1:0] == pic_pkg::OCW3_READ_IRR) begin
					prd_rb_armed = 1'b1;
					prd_rb_byte = prd_irr;
				end else if (d[1:0] == pic_pkg::OCW3_READ_ISR) begin
					prd_rb_armed = 1'b1;
					prd_rb_byte = prd_in_service & ~prd_mask;
				end
			end else begin
				case (d[7:5])
					pic_pkg::OCW2_ROT_CLEAR: prd_rot_base = 3'd0;
					pic_pkg::OCW2_NS_EOI: clear_first_in_service(found);
					pic_pkg::OCW2_NOP: ;
					pic_pkg::OCW2_SP_EOI, pic_pkg::OCW2_SP_EOI_ROT: begin
						if ((prd_in_service & b) != 0) begin
							prd_in_service &= ~b;
							prd_irr &= ~b;
							if (d[7:5] == pic_pkg::OCW2_SP_EOI_ROT)
								prd_rot_base++;
						end
					end
					pic_pkg::OCW2_ROT_INC: prd_rot_base++;
					pic_pkg::OCW2_NS_EOI_ROT: begin
						clear_first_in_service(found);
						if (found)
							prd_rot_base++;
					end
					default: prd_rot_base = d[2:0];
				endcase
			end
		end else if (prd_need_icw2) begin
			prd_vec_base = d[7:3];
			prd_need_icw2 = 1'b0;
		end else if (prd_need_icw3) begin
			prd_need_icw3 = 1'b0;
		end else if (prd_need_icw4) begin
			prd_need_icw4 = 1'b0;
		end else begin
			prd_mask = d;
			prd_in_service &= d;
			prd_irr &= d;
		end
		// ordered sweep of the pending lines after every write
		for (int i = 0; i < 8; i++)
			if (prd_irr[i])
				offer_line(i[2:0]);
	endtask

	task automatic compute_response(input pic_pkg::pic_req_t r,
			output pic_pkg::pic_res_t res);
		prd_raised = 1'b0;
		prd_vector = 8'd0;
		res.read_data = pic_pkg::READ_IDLE;
		case (r.mode)
			pic_pkg::MODE_WRITE: bus_write(r.address, r.write_data);
			pic_pkg::MODE_READ: begin
				if (r.address == pic_pkg::PORT_DATA) begin
					res.read_data = prd_mask;
				end else if (prd_rb_armed) begin
					prd_rb_armed = 1'b0;
					res.read_data = prd_rb_byte;
				end
			end
			pic_pkg::MODE_LINE: offer_line(r.irq_line);
			default: ;
		endcase
		res.int_raise = prd_raised;
		res.int_vector = prd_raised ? prd_vector : 8'd0;
		res.pending_bits = prd_irr;
	endtask

	task automatic queue_request(input logic [1:0] mode, input logic address,
			input logic [7:0] data, input logic [2:0] line);
		pic_pkg::pic_req_t r;
		r.mode = mode;
		r.address = address;
		r.write_data = data;
		r.irq_line = line;
		request_backlog.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
			send_gap = 0;
			sent = 0;
			calm <= 1'b0;
			prd_mask = pic_pkg::MASK_RESET;
			prd_in_service = 8'd0;
			prd_irr = 8'd0;
			prd_rot_base = 3'd0;
			prd_need_icw2 = 1'b0;
			prd_need_icw3 = 1'b0;
			prd_need_icw4 = 1'b0;
			prd_rb_armed = 1'b0;
			prd_rb_byte = 8'd0;
			prd_vec_base = 5'd0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				compute_response(req_ch.payload, next_res);
				predicted_results.push_back(next_res);
				sent++;
			end
			calm <= (request_backlog.size() < CALM_TAIL);
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 18);
					req_ch.valid <= 1'b0;
				end else if (request_backlog.size() == 0 ||
						(sent == drain_point && predicted_results.size() != 0)) begin
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.valid <= 1'b1;
					req_ch.payload <= request_backlog.pop_front();
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			take_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got_res = res_ch.payload;
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("result %h with no request outstanding", got_res));
				end else begin
					want_res = predicted_results.pop_front();
					if (got_res.read_data !== want_res.read_data)
						report_mismatch($sformatf("read_data got %h expected %h",
							got_res.read_data, want_res.read_data));
					if (got_res.int_raise !== want_res.int_raise)
						report_mismatch($sformatf("int_raise got %b expected %b",
							got_res.int_raise, want_res.int_raise));
					if (got_res.int_vector !== want_res.int_vector)
						report_mismatch($sformatf("int_vector got %h expected %h",
							got_res.int_vector, want_res.int_vector));
					if (got_res.pending_bits !== want_res.pending_bits)
						report_mismatch($sformatf("pending_bits got %h expected %h",
							got_res.pending_bits, want_res.pending_bits));
				end
			end
			if (take_gap > 0) begin
				take_gap--;
				res_ch.ready <= 1'b0;
			end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
				take_gap = $urandom_range(0, 18);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
			cycle_no <= '0;
		end else begin
			cycle_no <= cycle_no + 1;
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [7:0] d;
		int pick;
		mismatches = 0;
		drain_point = -1;

		// directed opening
		queue_request(pic_pkg::MODE_READ, pic_pkg::PORT_DATA, 8'h00, 3'd0);
		queue_request(pic_pkg::MODE_READ, pic_pkg::PORT_CMD, 8'hff, 3'd7);
		queue_request(pic_pkg::MODE_LINE, pic_pkg::PORT_CMD, 8'h00, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD, 8'h11, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'hf8, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'h00, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'hff, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'h00, 3'd0);
		queue_request(pic_pkg::MODE_LINE, pic_pkg::PORT_DATA, 8'hff, 3'd7);
		queue_request(pic_pkg::MODE_LINE, pic_pkg::PORT_CMD, 8'h00, 3'd3);
		queue_request(pic_pkg::MODE_LINE, pic_pkg::PORT_CMD, 8'h00, 3'd5);
		queue_request(pic_pkg::MODE_LINE, pic_pkg::PORT_CMD, 8'h00, 3'd3);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{3'b000, 2'b01, 1'b0, pic_pkg::OCW3_READ_IRR}, 3'd0);
		queue_request(pic_pkg::MODE_READ, pic_pkg::PORT_CMD, 8'h00, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{3'b011, 2'b01, 1'b1, pic_pkg::OCW3_READ_ISR}, 3'd0);
		queue_request(pic_pkg::MODE_READ, pic_pkg::PORT_CMD, 8'h00, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_NS_EOI, 5'd0}, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_SP_EOI, 2'b00, 3'd3}, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_ROT_INC, 5'd0}, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_NS_EOI_ROT, 5'd0}, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_SET_BASE, 2'b00, 3'd6}, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_SP_EOI_ROT, 2'b00, 3'd7}, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_NOP, 5'd0}, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD,
			{pic_pkg::OCW2_ROT_CLEAR, 5'd0}, 3'd0);
		queue_request(MODE_UNUSED, pic_pkg::PORT_DATA, 8'hff, 3'd7);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD, 8'hff, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'h07, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'h55, 3'd0);
		queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'h00, 3'd0);

		// hold the sender here until every directed result is back
		drain_point = request_backlog.size();

		while (request_backlog.size() < TOTAL_REQUESTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				queue_request(pic_pkg::MODE_LINE, 1'($urandom), 8'($urandom), 3'($urandom));
			end else if (pick < 60) begin
				d = 8'($urandom);
				d[4:3] = 2'b00;
				queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD, d, 3'($urandom));
			end else if (pick < 70) begin
				d = 8'($urandom);
				d[4:3] = 2'b01;
				queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD, d, 3'($urandom));
				queue_request(pic_pkg::MODE_READ, pic_pkg::PORT_CMD, 8'($urandom),
					3'($urandom));
			end else if (pick < 78) begin
				queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA,
					8'($urandom & $urandom & $urandom), 3'($urandom));
			end else if (pick < 83) begin
				queue_request(pic_pkg::MODE_READ, 1'($urandom), 8'($urandom), 3'($urandom));
			end else if (pick < 90) begin
				// initialisation sequence, now and then cut short
				d = 8'($urandom);
				d[4] = 1'b1;
				queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_CMD, d, 3'($urandom));
				queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'($urandom),
					3'($urandom));
				if (!d[1] && $urandom_range(0, 4) != 0)
					queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'($urandom),
						3'($urandom));
				if (d[0] && $urandom_range(0, 4) != 0)
					queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA, 8'($urandom),
						3'($urandom));
				queue_request(pic_pkg::MODE_WRITE, pic_pkg::PORT_DATA,
					8'($urandom & $urandom & $urandom), 3'($urandom));
			end else begin
				queue_request(2'($urandom), 1'($urandom), 8'($urandom), 3'($urandom));
			end
		end
		total_requests = request_backlog.size();

		@(posedge arst_n);
		while (sent != total_requests || predicted_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### priority_interrupt_controller.f
hw/rtl/pic_pkg.sv
hw/rtl/pic_stream_if.sv
hw/rtl/priority_interrupt_controller.sv
bench/priority_interrupt_controller_tb.sv
